// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the planar velocity slew limiter.
// Depends on nothing; the body is empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset
`define PVSL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen at a clock edge outside reset
`define PVSL_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PVSL_ASSERT(lbl, clk, rst_n, prop, msg)
`define PVSL_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== src/pvsl_pkg.sv =====
// Types, widths and codes for the planar velocity slew limiter.
// No dependencies; the RTL modules use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package pvsl_pkg;

    localparam int VEL_WIDTH = 16;
    localparam int STEP_W    = 15;
    localparam logic [STEP_W-1:0] STEP_RESET = 15'd410;

    // magnitude of a velocity difference
    localparam int MAG_W     = VEL_WIDTH + 1;
    // magnitude after scaling down to fit below 2^31
    localparam int SMAG_W    = (MAG_W > 31) ? 31 : MAG_W;
    localparam int SHIFT_MAX = (MAG_W > 31) ? MAG_W - 31 : 0;
    localparam int SHIFT_W   = (SHIFT_MAX > 0) ? $clog2(SHIFT_MAX + 1) : 1;
    localparam int SUM_W     = 2 * SMAG_W + 1;
    localparam int ROOT_W    = SMAG_W + 1;
    localparam int DIST_W    = ROOT_W + SHIFT_MAX;
    localparam int MUL_W     = (MAG_W > STEP_W) ? MAG_W : STEP_W;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SCL_W     = MAG_W + STEP_W;
    localparam int NUM_W     = SCL_W + 1;

    typedef struct packed {
        logic signed [VEL_WIDTH-1:0] target_vx;
        logic signed [VEL_WIDTH-1:0] target_vy;
        logic signed [VEL_WIDTH-1:0] target_wz;
        logic                        expired;
        logic                        velocity_mode;
    } tick_t;

    typedef struct packed {
        logic signed [VEL_WIDTH-1:0] out_vx;
        logic signed [VEL_WIDTH-1:0] out_vy;
        logic signed [VEL_WIDTH-1:0] out_wz;
        logic                        finished;
    } drive_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SQX,
        MUL_SQY,
        MUL_SQM,
        MUL_PRX,
        MUL_PRY
    } mul_op_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_PASS,
        RES_LIMIT
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_NORM,
        ST_SQX,
        ST_SQY,
        ST_SQM,
        ST_TEST,
        ST_PRX,
        ST_PRY,
        ST_ROOT,
        ST_DIV,
        ST_EMIT_ZERO,
        ST_EMIT_PASS,
        ST_EMIT_LIMIT
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    shift;
        mul_op_t mul_op;
        logic    sqrt_start;
        logic    div_start;
        logic    load_out;
        res_t    res;
    } dp_cmd_t;

    typedef struct packed {
        logic expired;
        logic vel_mode;
        logic need_shift;
        logic in_reach;
        logic sqrt_done;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/pvsl_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on pvsl_pkg for the radicand and root widths.
`timescale 1ns / 1ps
`default_nettype none

module pvsl_isqrt
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pvsl_pkg::SUM_W-1:0] radicand,
    output logic                       busy,
    output logic [pvsl_pkg::ROOT_W-1:0] root
);

    localparam int ISW = 2 * ((pvsl_pkg::SUM_W + 1) / 2);

    logic [ISW-1:0] n_reg, n_next;
    logic [ISW-1:0] root_reg, root_next;
    logic [ISW-1:0] mark_reg, mark_next;
    logic [ISW:0]   trial;

    assign trial = {1'b0, root_reg} + {1'b0, mark_reg};
    assign busy  = (mark_reg != '0);
    assign root  = root_reg[pvsl_pkg::ROOT_W-1:0];

    always_comb
    begin
        n_next    = n_reg;
        root_next = root_reg;
        mark_next = mark_reg;
        if (start)
        begin
            n_next    = ISW'(radicand);
            root_next = '0;
            mark_next = ISW'(1) << (ISW - 2);
        end
        else if (busy)
        begin
            if ({1'b0, n_reg} >= trial)
            begin
                n_next    = n_reg - trial[ISW-1:0];
                root_next = (root_reg >> 1) + mark_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            mark_next = mark_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= '0;
            root_reg <= '0;
        end
        else
        begin
            mark_reg <= mark_next;
            root_reg <= root_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
    end

endmodule

`default_nettype wire

// ===== src/pvsl_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pvsl_pkg for the numerator and divisor widths.
`timescale 1ns / 1ps
`default_nettype none

module pvsl_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pvsl_pkg::NUM_W-1:0]  num,
    input  logic [pvsl_pkg::DIST_W-1:0] den,
    output logic                        busy,
    output logic [pvsl_pkg::NUM_W-1:0]  quo
);

    localparam int NW    = pvsl_pkg::NUM_W;
    localparam int DW    = pvsl_pkg::DIST_W;
    localparam int CNT_W = $clog2(NW + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [NW-1:0]    quo_reg, quo_next;
    logic [DW:0]      trial;
    logic             qbit;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign qbit  = (trial >= {1'b0, den_reg});
    assign busy  = (cnt_reg != '0);
    assign quo   = quo_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        if (start)
        begin
            cnt_next = CNT_W'(NW);
            rem_next = '0;
            den_next = den;
            quo_next = num;
        end
        else if (busy)
        begin
            // remainder stays below the divisor, so it fits DW bits
            if (qbit)
                rem_next = DW'(trial - {1'b0, den_reg});
            else
                rem_next = trial[DW-1:0];
            quo_next = {quo_reg[NW-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

endmodule

`default_nettype wire

// ===== src/pvsl_dp.sv =====
// Datapath: stored command, step limit, shared multiplier, root and divider lanes,
// output register. Depends on pvsl_pkg, pvsl_isqrt and pvsl_div.
`timescale 1ns / 1ps
`default_nettype none

module pvsl_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pvsl_pkg::tick_t               tick,
    input  logic                          cfg_valid,
    input  logic [pvsl_pkg::STEP_W-1:0]   cfg_data,
    input  pvsl_pkg::dp_cmd_t             dcmd,
    output pvsl_pkg::dp_stat_t            stat,
    output logic                          drive_valid,
    input  logic                          drive_ready,
    output pvsl_pkg::drive_t              drive
);

    localparam int VW    = pvsl_pkg::VEL_WIDTH;
    localparam int MW    = pvsl_pkg::MAG_W;
    localparam int SW    = pvsl_pkg::STEP_W;
    localparam int UW    = pvsl_pkg::MUL_W;
    localparam int SUMW  = pvsl_pkg::SUM_W;
    localparam int DW    = pvsl_pkg::DIST_W;
    localparam int NW    = pvsl_pkg::NUM_W;
    localparam int CMP_W = (SUMW > 2 * SW) ? SUMW : 2 * SW;
    localparam int FW    = NW + 2;

    localparam logic signed [FW-1:0] SAT_HI = {{(FW - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
    localparam logic signed [FW-1:0] SAT_LO = {{(FW - VW + 1){1'b1}}, {(VW - 1){1'b0}}};

    function automatic logic signed [VW-1:0] sat_vel(input logic signed [FW-1:0] v);
        logic signed [VW-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[VW-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[VW-1:0];
        else
            r = v[VW-1:0];
        return r;
    endfunction

    logic [SW-1:0]          ms_reg;
    logic signed [VW-1:0]   last_vx_reg, last_vy_reg, last_wz_reg;
    logic signed [VW-1:0]   tx_reg, ty_reg, tw_reg;
    logic                   exp_reg, vm_reg;
    logic [MW-1:0]          ax_reg, ay_reg, sx_reg, sy_reg;
    logic                   negx_reg, negy_reg;
    logic [pvsl_pkg::SHIFT_W-1:0] sh_reg;
    logic [SUMW-1:0]        sq_reg;
    logic [2*SW-1:0]        msq_reg;
    logic [pvsl_pkg::SCL_W-1:0] prx_reg, pry_reg;
    logic                   drive_valid_reg;
    pvsl_pkg::drive_t       drive_reg, drive_next;

    logic signed [MW-1:0]   dx, dy;
    logic [MW-1:0]          ax_c, ay_c;
    logic [UW-1:0]          mul_a, mul_b;
    logic [pvsl_pkg::PROD_W-1:0] mul_p;
    logic                   sqrt_busy, divx_busy, divy_busy;
    logic [pvsl_pkg::ROOT_W-1:0] root;
    logic [DW-1:0]          dist_sh, dist_nz;
    logic [NW-1:0]          num_x, num_y, quo_x, quo_y;
    logic signed [FW-1:0]   qx, qy, fx, fy;

    // difference from the last command, taken as the item is captured
    assign dx   = MW'(tick.target_vx) - MW'(last_vx_reg);
    assign dy   = MW'(tick.target_vy) - MW'(last_vy_reg);
    assign ax_c = dx[MW-1] ? (~dx + 1'b1) : dx;
    assign ay_c = dy[MW-1] ? (~dy + 1'b1) : dy;

    always_comb
    begin
        case (dcmd.mul_op)
            pvsl_pkg::MUL_SQX:
            begin
                mul_a = UW'(sx_reg);
                mul_b = UW'(sx_reg);
            end
            pvsl_pkg::MUL_SQY:
            begin
                mul_a = UW'(sy_reg);
                mul_b = UW'(sy_reg);
            end
            pvsl_pkg::MUL_SQM:
            begin
                mul_a = UW'(ms_reg);
                mul_b = UW'(ms_reg);
            end
            pvsl_pkg::MUL_PRX:
            begin
                mul_a = UW'(ax_reg);
                mul_b = UW'(ms_reg);
            end
            pvsl_pkg::MUL_PRY:
            begin
                mul_a = UW'(ay_reg);
                mul_b = UW'(ms_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // root back to full scale; never divide by zero
    assign dist_sh = DW'(root) << sh_reg;
    assign dist_nz = (dist_sh == '0) ? DW'(1) : dist_sh;
    assign num_x   = NW'(prx_reg) + NW'(dist_nz >> 1);
    assign num_y   = NW'(pry_reg) + NW'(dist_nz >> 1);

    pvsl_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dcmd.sqrt_start),
        .radicand (sq_reg),
        .busy     (sqrt_busy),
        .root     (root)
    );

    pvsl_div u_div_x
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dcmd.div_start),
        .num   (num_x),
        .den   (dist_nz),
        .busy  (divx_busy),
        .quo   (quo_x)
    );

    pvsl_div u_div_y
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dcmd.div_start),
        .num   (num_y),
        .den   (dist_nz),
        .busy  (divy_busy),
        .quo   (quo_y)
    );

    assign qx = $signed({2'b00, quo_x});
    assign qy = $signed({2'b00, quo_y});
    assign fx = FW'(last_vx_reg) + (negx_reg ? -qx : qx);
    assign fy = FW'(last_vy_reg) + (negy_reg ? -qy : qy);

    always_comb
    begin
        case (dcmd.res)
            pvsl_pkg::RES_PASS:
            begin
                drive_next.out_vx   = tx_reg;
                drive_next.out_vy   = ty_reg;
                drive_next.out_wz   = tw_reg;
                drive_next.finished = 1'b0;
            end
            pvsl_pkg::RES_LIMIT:
            begin
                drive_next.out_vx   = sat_vel(fx);
                drive_next.out_vy   = sat_vel(fy);
                drive_next.out_wz   = tw_reg;
                drive_next.finished = 1'b0;
            end
            default:
            begin
                drive_next.out_vx   = '0;
                drive_next.out_vy   = '0;
                drive_next.out_wz   = '0;
                drive_next.finished = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        stat.expired    = exp_reg;
        stat.vel_mode   = vm_reg;
        stat.need_shift = ((sx_reg >> 31) != '0) || ((sy_reg >> 31) != '0);
        stat.in_reach   = (UW'(ax_reg) <= UW'(ms_reg)) && (UW'(ay_reg) <= UW'(ms_reg))
                          && (CMP_W'(sq_reg) <= CMP_W'(msq_reg));
        stat.sqrt_done  = !sqrt_busy;
        stat.div_done   = !divx_busy && !divy_busy;
        stat.out_free   = !drive_valid_reg || drive_ready;
    end

    // control and stored command state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg          <= pvsl_pkg::STEP_RESET;
            last_vx_reg     <= '0;
            last_vy_reg     <= '0;
            last_wz_reg     <= '0;
            drive_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                ms_reg <= cfg_data;
            if (dcmd.load_out)
            begin
                last_vx_reg     <= drive_next.out_vx;
                last_vy_reg     <= drive_next.out_vy;
                last_wz_reg     <= drive_next.out_wz;
                drive_valid_reg <= 1'b1;
            end
            else if (drive_ready)
            begin
                drive_valid_reg <= 1'b0;
            end
        end
    end

    // working registers of the item in flight
    always_ff @(posedge clk)
    begin
        if (dcmd.capture)
        begin
            tx_reg   <= tick.target_vx;
            ty_reg   <= tick.target_vy;
            tw_reg   <= tick.target_wz;
            exp_reg  <= tick.expired;
            vm_reg   <= tick.velocity_mode;
            ax_reg   <= ax_c;
            ay_reg   <= ay_c;
            sx_reg   <= ax_c;
            sy_reg   <= ay_c;
            negx_reg <= dx[MW-1];
            negy_reg <= dy[MW-1];
            sh_reg   <= '0;
        end
        else if (dcmd.shift)
        begin
            sx_reg <= sx_reg >> 1;
            sy_reg <= sy_reg >> 1;
            sh_reg <= sh_reg + 1'b1;
        end
        case (dcmd.mul_op)
            pvsl_pkg::MUL_SQX: sq_reg  <= SUMW'(mul_p);
            pvsl_pkg::MUL_SQY: sq_reg  <= sq_reg + SUMW'(mul_p);
            pvsl_pkg::MUL_SQM: msq_reg <= mul_p[2*SW-1:0];
            pvsl_pkg::MUL_PRX: prx_reg <= mul_p[pvsl_pkg::SCL_W-1:0];
            pvsl_pkg::MUL_PRY: pry_reg <= mul_p[pvsl_pkg::SCL_W-1:0];
            default:
            begin
                sq_reg <= sq_reg;
            end
        endcase
        if (dcmd.load_out)
            drive_reg <= drive_next;
    end

    assign drive_valid = drive_valid_reg;
    assign drive       = drive_reg;

endmodule

`default_nettype wire

// ===== src/pvsl_ctrl.sv =====
// Controller state machine: sequences capture, square sums, products, root, division and output load.
// Depends on pvsl_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module pvsl_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick_valid,
    output logic               tick_ready,
    output pvsl_pkg::dp_cmd_t  dcmd,
    input  pvsl_pkg::dp_stat_t stat
);

    pvsl_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pvsl_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        dcmd       = '0;
        tick_ready = 1'b0;
        case (state_reg)
            pvsl_pkg::ST_IDLE:
            begin
                tick_ready   = 1'b1;
                dcmd.capture = tick_valid;
                if (tick_valid)
                    state_next = pvsl_pkg::ST_CHECK;
            end
            pvsl_pkg::ST_CHECK:
            begin
                // expiry wins over the mode; other modes drop the transaction
                if (stat.expired)
                    state_next = pvsl_pkg::ST_EMIT_ZERO;
                else if (stat.vel_mode)
                    state_next = pvsl_pkg::ST_NORM;
                else
                    state_next = pvsl_pkg::ST_IDLE;
            end
            pvsl_pkg::ST_NORM:
            begin
                if (stat.need_shift)
                    dcmd.shift = 1'b1;
                else
                    state_next = pvsl_pkg::ST_SQX;
            end
            pvsl_pkg::ST_SQX:
            begin
                dcmd.mul_op = pvsl_pkg::MUL_SQX;
                state_next  = pvsl_pkg::ST_SQY;
            end
            pvsl_pkg::ST_SQY:
            begin
                dcmd.mul_op = pvsl_pkg::MUL_SQY;
                state_next  = pvsl_pkg::ST_SQM;
            end
            pvsl_pkg::ST_SQM:
            begin
                dcmd.mul_op = pvsl_pkg::MUL_SQM;
                state_next  = pvsl_pkg::ST_TEST;
            end
            pvsl_pkg::ST_TEST:
            begin
                if (stat.in_reach)
                begin
                    state_next = pvsl_pkg::ST_EMIT_PASS;
                end
                else
                begin
                    dcmd.sqrt_start = 1'b1;
                    state_next      = pvsl_pkg::ST_PRX;
                end
            end
            pvsl_pkg::ST_PRX:
            begin
                // the multiplier is free while the root runs
                dcmd.mul_op = pvsl_pkg::MUL_PRX;
                state_next  = pvsl_pkg::ST_PRY;
            end
            pvsl_pkg::ST_PRY:
            begin
                dcmd.mul_op = pvsl_pkg::MUL_PRY;
                state_next  = pvsl_pkg::ST_ROOT;
            end
            pvsl_pkg::ST_ROOT:
            begin
                if (stat.sqrt_done)
                begin
                    dcmd.div_start = 1'b1;
                    state_next     = pvsl_pkg::ST_DIV;
                end
            end
            pvsl_pkg::ST_DIV:
            begin
                if (stat.div_done)
                    state_next = pvsl_pkg::ST_EMIT_LIMIT;
            end
            pvsl_pkg::ST_EMIT_ZERO:
            begin
                dcmd.res = pvsl_pkg::RES_ZERO;
                if (stat.out_free)
                begin
                    dcmd.load_out = 1'b1;
                    state_next    = pvsl_pkg::ST_IDLE;
                end
            end
            pvsl_pkg::ST_EMIT_PASS:
            begin
                dcmd.res = pvsl_pkg::RES_PASS;
                if (stat.out_free)
                begin
                    dcmd.load_out = 1'b1;
                    state_next    = pvsl_pkg::ST_IDLE;
                end
            end
            pvsl_pkg::ST_EMIT_LIMIT:
            begin
                dcmd.res = pvsl_pkg::RES_LIMIT;
                if (stat.out_free)
                begin
                    dcmd.load_out = 1'b1;
                    state_next    = pvsl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pvsl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/planar_velocity_slew_limiter.sv =====
// Top level of the planar velocity slew limiter: controller plus datapath.
// Depends on pvsl_pkg, pvsl_ctrl, pvsl_dp and assert_macros.svh.
//
//   channel  | signals                       | payload
//   ---------+-------------------------------+---------------------------
//   tick     | tick_valid / tick_ready       | pvsl_pkg::tick_t
//   drive    | drive_valid / drive_ready     | pvsl_pkg::drive_t
//   cfg      | cfg_valid / cfg_ready (high)  | max_step, 15 bits
//
// One transaction at a time. Expiry and a pass-through step skip the root and
// the divider; a limited step runs the bit-serial square root and then the two
// divider lanes side by side, after the right shifts that very wide differences
// need. The drive output register lets the next tick be taken while a result
// waits; a new result stalls until that register is free.
// Reset clears the stored command to zero and max_step to 410.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module planar_velocity_slew_limiter
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        tick_valid,
    output logic                        tick_ready,
    input  pvsl_pkg::tick_t             tick,
    output logic                        drive_valid,
    input  logic                        drive_ready,
    output pvsl_pkg::drive_t            drive,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pvsl_pkg::STEP_W-1:0] cfg_data
);

    pvsl_pkg::dp_cmd_t  dcmd;
    pvsl_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    pvsl_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .dcmd       (dcmd),
        .stat       (stat)
    );

    pvsl_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .dcmd        (dcmd),
        .stat        (stat),
        .drive_valid (drive_valid),
        .drive_ready (drive_ready),
        .drive       (drive)
    );

    `PVSL_ASSERT(a_finish_is_zero, clk, rst_n, drive_valid && drive.finished |-> drive.out_vx == '0 && drive.out_vy == '0 && drive.out_wz == '0, "finished command is not zero")
    `PVSL_ASSERT_NEVER(a_no_overwrite, clk, rst_n, dcmd.load_out && drive_valid && !drive_ready, "result overwrites a waiting transaction")
    `PVSL_ASSERT_NEVER(a_units_idle, clk, rst_n, tick_ready && !(stat.sqrt_done && stat.div_done), "tick taken while root or divider busy")
    `PVSL_ASSERT_NEVER(a_div_after_root, clk, rst_n, dcmd.div_start && !stat.sqrt_done, "division started before the root is ready")

endmodule

`default_nettype wire
